[design/wsdfc_pkg.sv]
// Shared types and constants of the waveshaper with drive, fold and clip.
`default_nettype none
package wsdfc_pkg;

   // Shape modes
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_DRIVE = 2'd1;
   localparam logic [1:0] MODE_FOLD  = 2'd2;
   localparam logic [1:0] MODE_CLIP  = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_SHAPE_MODE    = 2'd0;
   localparam logic [1:0] REG_SHAPE_AMOUNT  = 2'd1;
   localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd2;

   localparam logic [16:0] GAIN_ONE      = 17'd65536;
   localparam logic [16:0] GAIN_MIN      = 17'd65;
   localparam logic [30:0] EXP_M1_Q32    = 31'd1580030169;
   localparam logic [17:0] CLIP_FLOOR    = 18'd6554;
   localparam logic [3:0]  TAYLOR_TERMS  = 4'd14;
   localparam logic [4:0]  FOLD_MAX      = 5'd16;
   // 1/5 in Q18, rounded up; exact quotient for amounts up to 1.0
   localparam logic [15:0] FIVE_RECIP_Q18 = 16'd52429;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_SET_TD_ARG,
      CMD_EXP_INIT,
      CMD_EXP_MUL,
      CMD_TERM_DIV,
      CMD_EXP_ACC,
      CMD_POW_INIT,
      CMD_POW_MUL,
      CMD_TANH_DIV,
      CMD_TANH_STORE,
      CMD_RATIO_DIV,
      CMD_RATIO_STORE,
      CMD_FOLD_DIV,
      CMD_FOLD_SET,
      CMD_FOLD_STEP,
      CMD_CLIP_DIV,
      CMD_CLIP_STORE,
      CMD_FB_MUL,
      CMD_FB_ADD,
      CMD_EMIT
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EXP_INIT,
      ST_EXP_MUL,
      ST_TERM_DIV,
      ST_TERM_WAIT,
      ST_POW_INIT,
      ST_POW,
      ST_TANH_WAIT,
      ST_RATIO_DIV,
      ST_RATIO_WAIT,
      ST_FOLD_WAIT,
      ST_FOLD,
      ST_CLIP_WAIT,
      ST_FB_MUL,
      ST_FB_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       shape_on;
      logic       fb_on;
      logic       div_done;
      logic       n_last;
      logic       k_zero;
      logic       on_tn;
      logic       fold_more;
   } status_type;

endpackage
`default_nettype wire

[design/wsdfc_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module wsdfc_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [6:0]  cnt,
   input  wire logic [33:0] den,
   output logic             done,
   output logic [63:0]      quo
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  left_ff, left_in;
   logic [63:0] num_ff, num_in;
   logic [33:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [33:0] den_ff, den_in;
   logic [34:0] trial;
   logic [34:0] diff;
   logic        take;

   always_comb begin
      trial   = {rem_ff, num_ff[63]};
      diff    = trial - {1'b0, den_ff};
      take    = ~diff[34];
      busy_in = busy_ff;
      done_in = 1'b0;
      left_in = left_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         left_in = cnt;
         num_in  = num << (7'd64 - cnt);
         rem_in  = '0;
         quo_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         // shift in the next numerator bit and subtract where it fits
         rem_in  = take ? diff[33:0] : trial[33:0];
         quo_in  = {quo_ff[62:0], take};
         num_in  = {num_ff[62:0], 1'b0};
         left_in = left_ff - 7'd1;
         if (left_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         left_ff <= left_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

[design/wsdfc_ctrl.sv]
// Sequencer of the waveshaper: steps the datapath through one transaction.
`default_nettype none
module wsdfc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire wsdfc_pkg::status_type  status,
   output wsdfc_pkg::cmd_type          cmd
);
   import wsdfc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_NOP;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!status.shape_on) begin
               state_in = ST_FB_MUL;
            end else begin
               unique case (status.mode)
                  MODE_DRIVE: begin
                     cmd      = CMD_SET_TD_ARG;
                     state_in = ST_EXP_INIT;
                  end
                  MODE_FOLD: begin
                     cmd      = CMD_FOLD_DIV;
                     state_in = ST_FOLD_WAIT;
                  end
                  MODE_CLIP: begin
                     cmd      = CMD_CLIP_DIV;
                     state_in = ST_CLIP_WAIT;
                  end
                  default: state_in = ST_FB_MUL;
               endcase
            end
         end
         ST_EXP_INIT: begin
            cmd      = CMD_EXP_INIT;
            state_in = ST_EXP_MUL;
         end
         ST_EXP_MUL: begin
            cmd      = CMD_EXP_MUL;
            state_in = ST_TERM_DIV;
         end
         ST_TERM_DIV: begin
            cmd      = CMD_TERM_DIV;
            state_in = ST_TERM_WAIT;
         end
         ST_TERM_WAIT: begin
            if (status.div_done) begin
               cmd      = CMD_EXP_ACC;
               state_in = status.n_last ? ST_POW_INIT : ST_EXP_MUL;
            end
         end
         ST_POW_INIT: begin
            cmd      = CMD_POW_INIT;
            state_in = ST_POW;
         end
         ST_POW: begin
            if (status.k_zero) begin
               cmd      = CMD_TANH_DIV;
               state_in = ST_TANH_WAIT;
            end else begin
               cmd = CMD_POW_MUL;
            end
         end
         ST_TANH_WAIT: begin
            if (status.div_done) begin
               cmd      = CMD_TANH_STORE;
               state_in = status.on_tn ? ST_RATIO_DIV : ST_EXP_INIT;
            end
         end
         ST_RATIO_DIV: begin
            cmd      = CMD_RATIO_DIV;
            state_in = ST_RATIO_WAIT;
         end
         ST_RATIO_WAIT: begin
            if (status.div_done) begin
               cmd      = CMD_RATIO_STORE;
               state_in = ST_FB_MUL;
            end
         end
         ST_FOLD_WAIT: begin
            // threshold quotient registered last cycle, finish it now
            cmd      = CMD_FOLD_SET;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (status.fold_more) begin
               cmd = CMD_FOLD_STEP;
            end else begin
               state_in = ST_FB_MUL;
            end
         end
         ST_CLIP_WAIT: begin
            if (status.div_done) begin
               cmd      = CMD_CLIP_STORE;
               state_in = ST_FB_MUL;
            end
         end
         ST_FB_MUL: begin
            cmd      = CMD_FB_MUL;
            state_in = ST_FB_ADD;
         end
         ST_FB_ADD: begin
            cmd      = CMD_FB_ADD;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd          = CMD_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_EMIT |-> !(rsp_valid_ff && rsp_stall))
      else $error("result written over a waiting result");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_EMIT |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("emitted result not presented");
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_DISPATCH)
      else $error("accepted transaction not started");

endmodule
`default_nettype wire

[design/wsdfc_datapath.sv]
// Datapath of the waveshaper: registers, multipliers and the shared divider.
`default_nettype none
module wsdfc_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wsdfc_pkg::cmd_type    cmd,
   output wsdfc_pkg::status_type      status,
   input  wire logic signed [15:0]    req_sample_in,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [16:0]           csr_wdata,
   output logic signed [15:0]         rsp_sample_out
);
   import wsdfc_pkg::*;

   localparam logic signed [34:0] Q31_ONE = 35'sh0_8000_0000;

   logic [1:0]         mode_ff;
   logic [16:0]        amount_ff;
   logic [16:0]        feedback_ff;
   logic signed [15:0] last_ff;
   logic signed [15:0] out_ff;

   logic signed [15:0] x_ff;
   logic signed [34:0] s_ff;
   logic [37:0]        y_ff;
   logic [31:0]        term_ff;
   logic signed [34:0] sum_ff;
   logic [3:0]         n_ff;
   logic [32:0]        v_ff;
   logic [5:0]         k_ff;
   logic [30:0]        td_ff;
   logic [30:0]        tn_ff;
   logic               on_tn_ff;
   logic signed [34:0] t_ff;
   logic [4:0]         iter_ff;
   logic signed [33:0] fb_prod_ff;
   logic [13:0]        fold_q_ff;

   logic [16:0]        a_sat;
   logic [16:0]        f_sat;
   logic [19:0]        d_val;
   logic [15:0]        x_mag;
   logic [35:0]        mag_d;
   logic [63:0]        exp_prod;
   logic [63:0]        pow_prod;
   logic signed [33:0] fb_prod;
   logic [17:0]        lim_raw;
   logic [17:0]        lim;
   logic [17:0]        clip_full;
   logic [17:0]        clip_mag;
   logic [32:0]        one_minus_v;
   logic signed [34:0] q_signed;
   logic signed [34:0] fb_sum;
   logic signed [34:0] rnd;
   logic signed [18:0] r19;
   logic signed [15:0] r16;
   logic [31:0]        fold_prod;
   logic [2:0]         fold_rem;
   logic [16:0]        fold_frac;
   logic [31:0]        fold_thr;

   logic               div_start;
   logic [63:0]        div_num;
   logic [6:0]         div_cnt;
   logic [33:0]        div_den;
   logic               div_done;
   logic [63:0]        div_quo;

   wsdfc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .cnt   (div_cnt),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      a_sat       = (amount_ff > GAIN_ONE) ? GAIN_ONE : amount_ff;
      f_sat       = (feedback_ff > GAIN_ONE) ? GAIN_ONE : feedback_ff;
      d_val       = 20'd65536 + 20'(a_sat) + {a_sat, 3'b000};
      x_mag       = x_ff[15] ? 16'(-x_ff) : 16'(x_ff);
      mag_d       = 36'(x_mag) * 36'(d_val);
      exp_prod    = 64'(term_ff) * 64'(y_ff[31:0]);
      pow_prod    = 64'(v_ff) * 64'(EXP_M1_Q32);
      fb_prod     = 34'(last_ff) * 34'($signed({1'b0, f_sat}));
      lim_raw     = 18'd131072 - 18'(a_sat);
      lim         = (lim_raw < CLIP_FLOOR) ? CLIP_FLOOR : lim_raw;
      clip_full   = {x_mag, 2'b00};
      clip_mag    = (clip_full > lim) ? lim : clip_full;
      one_minus_v = 33'h1_0000_0000 - v_ff;
      q_signed    = $signed({2'b00, div_quo[32:0]});
      fb_sum      = s_ff + 35'(fb_prod_ff);
      rnd         = s_ff + 35'sd32768;
      r19         = rnd[34:16];
      if (r19 > 19'sd32767) begin
         r16 = 16'sh7FFF;
      end else if (r19 < -19'sd32768) begin
         r16 = 16'sh8000;
      end else begin
         r16 = r19[15:0];
      end
      // fold threshold amount*2^17/5, rounded: split amount into 5q + r,
      // then q*2^17 plus a small table for r*2^17/5
      fold_prod   = 32'(a_sat) * 32'(FIVE_RECIP_Q18);
      fold_rem    = 3'(a_sat - 17'({fold_q_ff, 2'b00}) - 17'(fold_q_ff));
      unique case (fold_rem)
         3'd1:    fold_frac = 17'd26214;
         3'd2:    fold_frac = 17'd52429;
         3'd3:    fold_frac = 17'd78643;
         3'd4:    fold_frac = 17'd104858;
         default: fold_frac = 17'd0;
      endcase
      fold_thr    = 32'({fold_q_ff, 17'b0}) + 32'(fold_frac);
   end

   // Divider operand selection
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_cnt   = '0;
      div_den   = '0;
      unique case (cmd)
         CMD_TERM_DIV: begin
            div_start = 1'b1;
            div_num   = 64'(term_ff);
            div_cnt   = 7'd32;
            div_den   = 34'(n_ff);
         end
         CMD_TANH_DIV: begin
            div_start = 1'b1;
            div_num   = 64'({one_minus_v, 30'b0});
            div_cnt   = 7'd63;
            div_den   = 34'h1_0000_0000 + 34'(v_ff);
         end
         CMD_RATIO_DIV: begin
            div_start = 1'b1;
            div_num   = 64'({tn_ff, 31'b0}) + 64'(td_ff[30:1]);
            div_cnt   = 7'd62;
            div_den   = 34'(td_ff);
         end
         CMD_CLIP_DIV: begin
            div_start = 1'b1;
            div_num   = 64'({clip_mag, 31'b0}) + 64'(lim[17:1]);
            div_cnt   = 7'd49;
            div_den   = 34'(lim);
         end
         default: div_start = 1'b0;
      endcase
   end

   // Configuration and history
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NONE;
         amount_ff   <= '0;
         feedback_ff <= '0;
         last_ff     <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_SHAPE_MODE:    mode_ff     <= csr_wdata[1:0];
               REG_SHAPE_AMOUNT:  amount_ff   <= csr_wdata;
               REG_FEEDBACK_GAIN: feedback_ff <= csr_wdata;
               default:           mode_ff     <= mode_ff;
            endcase
         end
         if (cmd == CMD_EMIT) begin
            last_ff <= r16;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_LOAD: begin
            x_ff <= req_sample_in;
            s_ff <= {{3{req_sample_in[15]}}, req_sample_in, 16'b0};
         end
         CMD_SET_TD_ARG: begin
            y_ff     <= 38'({d_val, 17'b0});
            on_tn_ff <= 1'b0;
         end
         CMD_EXP_INIT: begin
            term_ff <= y_ff[31:0];
            sum_ff  <= 35'sh1_0000_0000 - $signed({3'b000, y_ff[31:0]});
            n_ff    <= 4'd2;
         end
         CMD_EXP_MUL: term_ff <= exp_prod[63:32];
         CMD_EXP_ACC: begin
            term_ff <= div_quo[31:0];
            if (n_ff[0]) begin
               sum_ff <= sum_ff - $signed({3'b000, div_quo[31:0]});
            end else begin
               sum_ff <= sum_ff + $signed({3'b000, div_quo[31:0]});
            end
            n_ff <= n_ff + 4'd1;
         end
         CMD_POW_INIT: begin
            v_ff <= sum_ff[34] ? 33'd0 : sum_ff[32:0];
            k_ff <= y_ff[37:32];
         end
         CMD_POW_MUL: begin
            v_ff <= 33'(pow_prod[63:32]);
            k_ff <= k_ff - 6'd1;
         end
         CMD_TANH_STORE: begin
            if (on_tn_ff) begin
               tn_ff <= div_quo[30:0];
            end else begin
               td_ff    <= div_quo[30:0];
               y_ff     <= {mag_d, 2'b00};
               on_tn_ff <= 1'b1;
            end
         end
         CMD_RATIO_STORE, CMD_CLIP_STORE: s_ff <= x_ff[15] ? -q_signed : q_signed;
         CMD_FOLD_DIV: fold_q_ff <= fold_prod[31:18];
         CMD_FOLD_SET: begin
            t_ff    <= Q31_ONE - $signed({3'b000, fold_thr});
            iter_ff <= '0;
         end
         CMD_FOLD_STEP: begin
            // reflect about the nearer threshold
            if (s_ff > 35'sd0) begin
               s_ff <= (t_ff <<< 1) - s_ff;
            end else begin
               s_ff <= -(t_ff <<< 1) - s_ff;
            end
            iter_ff <= iter_ff + 5'd1;
         end
         CMD_FB_MUL: fb_prod_ff <= fb_prod;
         CMD_FB_ADD: begin
            if (status.fb_on) begin
               if (fb_sum > Q31_ONE) begin
                  s_ff <= Q31_ONE;
               end else if (fb_sum < -Q31_ONE) begin
                  s_ff <= -Q31_ONE;
               end else begin
                  s_ff <= fb_sum;
               end
            end
         end
         CMD_EMIT: out_ff <= r16;
         default: x_ff <= x_ff;
      endcase
   end

   always_comb begin
      status.mode      = mode_ff;
      status.shape_on  = a_sat > GAIN_MIN;
      status.fb_on     = f_sat > GAIN_MIN;
      status.div_done  = div_done;
      status.n_last    = n_ff == TAYLOR_TERMS;
      status.k_zero    = k_ff == 6'd0;
      status.on_tn     = on_tn_ff;
      status.fold_more = (s_ff > t_ff || s_ff < -t_ff) && iter_ff < FOLD_MAX;
   end

   assign rsp_sample_out = out_ff;

endmodule
`default_nettype wire

[design/waveshaper_drive_fold_clip.sv]
// Work per transaction: shaping off runs only feedback and rounding; fold runs at most 16
// reflections; clip runs one division; tanh drive runs two exp evaluations of 13 series
// terms through the shared one-bit-per-cycle divider, with up to 20 power steps each.
// Throughput: one transaction at a time; the next is taken once the current one
// has been written to the output register, which a stalled consumer may still hold.
// Reset (synchronous, active high) clears the configuration registers, the history and the sequencer.
`default_nettype none
module waveshaper_drive_fold_clip (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_sample_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_sample_out,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [16:0]        csr_wdata
);
   import wsdfc_pkg::*;

   // Command from the sequencer, status back from the datapath
   cmd_type    cmd;
   status_type status;

   // The sequencer walks drive (exp series, powers of e^-1, two tanh
   // divisions and the ratio), fold (threshold by reciprocal multiply, then
   // one reflection a cycle) or clip (one division), then feedback and rounding.
   wsdfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the registers, the last output and the divider.
   wsdfc_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule
`default_nettype wire
